// ===== design/rrqs_pkg.sv =====
// Shared constants, command codes, and interface types for the round-robin quantum scheduler.
package rrqs_pkg;

    // Depth of the ready queue, in task slots.
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int TASK_W = 4;
    localparam int CMD_W  = 2;
    localparam int QNT_W  = 16;
    localparam int RCNT_W = 5;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Command codes carried in the request.
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_YIELD = 2'd3;

    // Register index, taken from the word-select bit of the address.
    localparam logic REG_QUANTUM = 1'b0;

    localparam logic [QNT_W-1:0] QUANTUM_RESET = 16'd10;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [TASK_W-1:0] push_id;
    } t_queue_ctl;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [TASK_W-1:0] head_id;
    } t_queue_stat;

    typedef struct packed {
        logic [TASK_W-1:0] current_task;
        logic              switched;
        logic              add_rejected;
        logic [RCNT_W-1:0] ready_count;
        logic [QNT_W-1:0]  quantum_left;
        logic              current_exited;
    } t_result;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(MAX_TASKS - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

// ===== design/round_robin_quantum_scheduler_top.sv =====
// Top level of the round-robin quantum scheduler.
// This block runs a round-robin scheduler: a 16-deep FIFO of ready task ids
// feeds one running task (the idle task 0 after reset), and a quantum counter
// preempts it. Each request carries a command (add, tick, exit, yield) and a
// task id; each request produces exactly one response showing the running
// task, whether a switch happened, whether an add was rejected, the queue
// fill, the remaining quantum and the exit flag. A request is registered on
// entry, executed in one pass of short logic against the scheduler state,
// and its response is then captured in the output register. One request is
// accepted every clock cycle while the response side does not stall; the rate
// is set by the single state update per cycle, in which the queue push, pop
// and counter reload all complete. The output register decouples the sides,
// so a new request is taken while an earlier response still waits. The quantum
// length is written through the APB port at byte address 0 and should only
// change while the block is idle; pready is always high.
module round_robin_quantum_scheduler_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rrqs_pkg::CMD_W-1:0]  i_cmd,
    input  logic [rrqs_pkg::TASK_W-1:0] i_task_id,
    // Response channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rrqs_pkg::TASK_W-1:0] o_current_task,
    output logic                        o_switched,
    output logic                        o_add_rejected,
    output logic [rrqs_pkg::RCNT_W-1:0] o_ready_count,
    output logic [rrqs_pkg::QNT_W-1:0]  o_quantum_left,
    output logic                        o_current_exited,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrqs_pkg::APB_AW-1:0] paddr,
    input  logic [rrqs_pkg::APB_DW-1:0] pwdata,
    output logic [rrqs_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    // Input register.
    logic                        r_in_valid;
    logic [rrqs_pkg::CMD_W-1:0]  r_cmd;
    logic [rrqs_pkg::TASK_W-1:0] r_task_id;

    // Output register.
    logic                        r_out_valid;
    rrqs_pkg::t_result           r_result;

    logic                        advance;
    logic                        exec;
    logic [rrqs_pkg::QNT_W-1:0]  quantum_length;
    rrqs_pkg::t_queue_ctl        qctl;
    rrqs_pkg::t_queue_stat       qstat;
    rrqs_pkg::t_result           result;

    // The output register can take a new response when it is empty or its
    // current one is being taken; the held request executes at that edge.
    assign advance    = !r_out_valid || i_out_ready;
    assign exec       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd     <= i_cmd;
            r_task_id <= i_task_id;
        end
    end

    rrqs_apb u_apb (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_quantum_length (quantum_length)
    );

    rrqs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .o_stat  (qstat)
    );

    rrqs_sched u_sched (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_exec           (exec),
        .i_cmd            (r_cmd),
        .i_task_id        (r_task_id),
        .i_quantum_length (quantum_length),
        .i_qstat          (qstat),
        .o_qctl           (qctl),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_current_task   = r_result.current_task;
    assign o_switched       = r_result.switched;
    assign o_add_rejected   = r_result.add_rejected;
    assign o_ready_count    = r_result.ready_count;
    assign o_quantum_left   = r_result.quantum_left;
    assign o_current_exited = r_result.current_exited;

endmodule

// ===== design/rrqs_queue.sv =====
// Circular FIFO of ready task ids with head, tail and fill count.
module rrqs_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrqs_pkg::t_queue_ctl i_ctl,
    output rrqs_pkg::t_queue_stat o_stat
);

    logic [rrqs_pkg::TASK_W-1:0] r_entry [rrqs_pkg::MAX_TASKS];
    logic [rrqs_pkg::IDX_W-1:0]  r_head;
    logic [rrqs_pkg::IDX_W-1:0]  r_tail;
    logic [rrqs_pkg::CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.push) begin
                r_tail <= rrqs_pkg::next_idx(r_tail);
            end
            if (i_ctl.pop) begin
                r_head <= rrqs_pkg::next_idx(r_head);
            end
            r_count <= r_count + rrqs_pkg::CNT_W'(i_ctl.push)
                               - rrqs_pkg::CNT_W'(i_ctl.pop);
        end
    end

    // On a pop with push into a full queue the head entry is read before the
    // tail write lands on the same slot.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry[r_tail] <= i_ctl.push_id;
        end
    end

    assign o_stat.count   = r_count;
    assign o_stat.head_id = r_entry[r_head];

endmodule

// ===== design/rrqs_sched.sv =====
// Running task, quantum countdown and exit flag, with the per-command decision logic.
module rrqs_sched (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_exec,
    input  logic [rrqs_pkg::CMD_W-1:0]  i_cmd,
    input  logic [rrqs_pkg::TASK_W-1:0] i_task_id,
    input  logic [rrqs_pkg::QNT_W-1:0]  i_quantum_length,
    input  rrqs_pkg::t_queue_stat       i_qstat,
    output rrqs_pkg::t_queue_ctl        o_qctl,
    output rrqs_pkg::t_result           o_result
);

    logic [rrqs_pkg::TASK_W-1:0] r_running;
    logic [rrqs_pkg::QNT_W-1:0]  r_quantum;
    logic                        r_exited;

    logic [rrqs_pkg::TASK_W-1:0] n_running;
    logic [rrqs_pkg::QNT_W-1:0]  n_quantum;
    logic                        n_exited;

    logic [rrqs_pkg::QNT_W-1:0]  quantum_dec;
    logic [rrqs_pkg::CNT_W-1:0]  count_after;
    logic                        try_yield;
    logic                        exited_eff;
    logic                        switched;
    logic                        rejected;
    rrqs_pkg::t_queue_ctl        ctl;

    assign quantum_dec = (r_quantum != '0) ? r_quantum - 1'b1 : '0;

    always_comb begin
        n_running  = r_running;
        n_quantum  = r_quantum;
        n_exited   = r_exited;
        ctl        = '0;
        try_yield  = 1'b0;
        exited_eff = r_exited;
        switched   = 1'b0;
        rejected   = 1'b0;

        case (i_cmd)
            rrqs_pkg::CMD_ADD: begin
                if (i_qstat.count == rrqs_pkg::CNT_W'(rrqs_pkg::MAX_TASKS)) begin
                    rejected = 1'b1;
                end else begin
                    ctl.push    = 1'b1;
                    ctl.push_id = i_task_id;
                end
            end
            rrqs_pkg::CMD_TICK: begin
                n_quantum = quantum_dec;
                try_yield = (quantum_dec == '0);
            end
            rrqs_pkg::CMD_EXIT: begin
                exited_eff = 1'b1;
                n_exited   = 1'b1;
                try_yield  = 1'b1;
            end
            default: begin
                try_yield = 1'b1;
            end
        endcase

        // A switch pops the head; the outgoing task goes back to the tail
        // unless it has exited. After the pop there is always room for it.
        if (try_yield && (i_qstat.count != '0)) begin
            ctl.pop   = 1'b1;
            switched  = 1'b1;
            n_running = i_qstat.head_id;
            n_exited  = 1'b0;
            n_quantum = i_quantum_length;
            if (!exited_eff) begin
                ctl.push    = 1'b1;
                ctl.push_id = r_running;
            end
        end
    end

    assign count_after = i_qstat.count + rrqs_pkg::CNT_W'(ctl.push)
                                       - rrqs_pkg::CNT_W'(ctl.pop);

    assign o_qctl = i_exec ? ctl : '0;

    assign o_result.current_task   = n_running;
    assign o_result.switched       = switched;
    assign o_result.add_rejected   = rejected;
    assign o_result.ready_count    = rrqs_pkg::RCNT_W'(count_after);
    assign o_result.quantum_left   = n_quantum;
    assign o_result.current_exited = n_exited;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_quantum <= rrqs_pkg::QUANTUM_RESET;
            r_exited  <= 1'b0;
        end else if (i_exec) begin
            r_running <= n_running;
            r_quantum <= n_quantum;
            r_exited  <= n_exited;
        end
    end

endmodule

// ===== design/rrqs_apb.sv =====
// APB register slave holding the quantum length.
module rrqs_apb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrqs_pkg::APB_AW-1:0] paddr,
    input  logic [rrqs_pkg::APB_DW-1:0] pwdata,
    output logic [rrqs_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [rrqs_pkg::QNT_W-1:0]  o_quantum_length
);

    logic [rrqs_pkg::QNT_W-1:0] r_quantum_length;
    logic                       sel_quantum;

    assign pready      = 1'b1;
    assign sel_quantum = (paddr[rrqs_pkg::APB_AW-1] == rrqs_pkg::REG_QUANTUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum_length <= rrqs_pkg::QUANTUM_RESET;
        end else if (psel && penable && pwrite && pready && sel_quantum) begin
            r_quantum_length <= pwdata[rrqs_pkg::QNT_W-1:0];
        end
    end

    assign prdata = sel_quantum ? rrqs_pkg::APB_DW'(r_quantum_length) : '0;
    assign o_quantum_length = r_quantum_length;

endmodule

// ===== design/rrqs_checker.sv =====
// Port-level assertions for the scheduler top level, with the bind that attaches them.
module rrqs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [rrqs_pkg::TASK_W-1:0] o_current_task,
    input logic                        o_switched,
    input logic                        o_add_rejected,
    input logic [rrqs_pkg::RCNT_W-1:0] o_ready_count,
    input logic [rrqs_pkg::QNT_W-1:0]  o_quantum_left,
    input logic                        o_current_exited
);

    // Reset empties the response register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    // A stalled response holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_current_task)
            && $stable(o_switched) && $stable(o_add_rejected)
            && $stable(o_ready_count) && $stable(o_quantum_left)
            && $stable(o_current_exited))
        else $error("stalled response changed");

    // A switch always clears the exit flag and never goes with a rejected add.
    a_switch_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_switched |-> !o_current_exited && !o_add_rejected)
        else $error("switch response inconsistent");

    // An add is only rejected with a full queue.
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_add_rejected
            |-> o_ready_count == rrqs_pkg::RCNT_W'(rrqs_pkg::MAX_TASKS))
        else $error("add rejected while queue not full");

endmodule

bind round_robin_quantum_scheduler_top rrqs_checker u_rrqs_checker (.*);

// ===== dv/round_robin_quantum_scheduler_top_tb.sv =====
// Self-checking testbench for the round-robin quantum scheduler top level.
`timescale 1ns / 1ps

module round_robin_quantum_scheduler_top_tb;
    import rrqs_pkg::*;

    // The quantum length register is register zero, four bytes per register.
    localparam logic [APB_AW-1:0] QUANTUM_ADDR = APB_AW'(4 * REG_QUANTUM);
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASE_COUNT = 7;
    // Quantum settings walked by the random phases; one phase draws its own.
    localparam int unsigned QUANTUM_PLAN[PHASE_COUNT] = '{1, 0, 65535, 3, 2, 6, 10};
    localparam int DRAWN_PHASE = 5;
    localparam int STEADY_PHASE = 3;

    // One row of the directed table. Rows with a typed result are checked
    // against it as well as against the predictor.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TASK_W-1:0] id;
        logic              typed;
        t_result           result;
    } t_sched_row;

    typedef struct {
        t_result predicted;
        logic    typed;
        t_result written;
    } t_awaited;

    // Starting from reset: yields and exits on an empty queue, a duplicate id,
    // a full queue that rejects an add, then a yield and an exit while full.
    localparam t_sched_row DIRECTED[25] = '{
        '{CMD_YIELD, 4'd0,  1'b1, '{4'd0,  1'b0, 1'b0, 5'd0,  16'd10, 1'b0}},
        '{CMD_TICK,  4'd0,  1'b1, '{4'd0,  1'b0, 1'b0, 5'd0,  16'd9,  1'b0}},
        '{CMD_EXIT,  4'd0,  1'b1, '{4'd0,  1'b0, 1'b0, 5'd0,  16'd9,  1'b1}},
        '{CMD_EXIT,  4'd9,  1'b1, '{4'd0,  1'b0, 1'b0, 5'd0,  16'd9,  1'b1}},
        '{CMD_ADD,   4'd15, 1'b1, '{4'd0,  1'b0, 1'b0, 5'd1,  16'd9,  1'b1}},
        '{CMD_YIELD, 4'd6,  1'b1, '{4'd15, 1'b1, 1'b0, 5'd0,  16'd10, 1'b0}},
        '{CMD_ADD,   4'd15, 1'b0, '0},
        '{CMD_ADD,   4'd0,  1'b0, '0},
        '{CMD_ADD,   4'd5,  1'b0, '0},
        '{CMD_ADD,   4'd10, 1'b0, '0},
        '{CMD_ADD,   4'd3,  1'b0, '0},
        '{CMD_ADD,   4'd12, 1'b0, '0},
        '{CMD_ADD,   4'd6,  1'b0, '0},
        '{CMD_ADD,   4'd9,  1'b0, '0},
        '{CMD_ADD,   4'd1,  1'b0, '0},
        '{CMD_ADD,   4'd14, 1'b0, '0},
        '{CMD_ADD,   4'd2,  1'b0, '0},
        '{CMD_ADD,   4'd13, 1'b0, '0},
        '{CMD_ADD,   4'd4,  1'b0, '0},
        '{CMD_ADD,   4'd11, 1'b0, '0},
        '{CMD_ADD,   4'd7,  1'b0, '0},
        '{CMD_ADD,   4'd8,  1'b0, '0},
        '{CMD_ADD,   4'd7,  1'b1, '{4'd15, 1'b0, 1'b1, 5'd16, 16'd10, 1'b0}},
        '{CMD_YIELD, 4'd0,  1'b0, '0},
        '{CMD_EXIT,  4'd0,  1'b0, '0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [CMD_W-1:0]  i_cmd = CMD_ADD;
    logic [TASK_W-1:0] i_task_id = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [TASK_W-1:0] o_current_task;
    logic              o_switched;
    logic              o_add_rejected;
    logic [RCNT_W-1:0] o_ready_count;
    logic [QNT_W-1:0]  o_quantum_left;
    logic              o_current_exited;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Typed result of the directed row currently offered, held with the payload.
    logic    row_typed = 1'b0;
    t_result row_result = '0;

    // When set, neither side inserts gaps or stalls.
    logic steady = 1'b0;

    // Predicted scheduler state, kept in step with every accepted request.
    logic [TASK_W-1:0] ready_ring [MAX_TASKS];
    int unsigned       ring_head = 0;
    int unsigned       ring_tail = 0;
    int unsigned       ring_fill = 0;
    logic [TASK_W-1:0] running_id = '0;
    logic [QNT_W-1:0]  quantum_count = QUANTUM_RESET;
    logic [QNT_W-1:0]  quantum_len = QUANTUM_RESET;
    logic              task_exited = 1'b0;

    t_awaited awaited_responses [$];
    int       mismatch_count = 0;

    round_robin_quantum_scheduler_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_task_id        (i_task_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_current_task   (o_current_task),
        .o_switched       (o_switched),
        .o_add_rejected   (o_add_rejected),
        .o_ready_count    (o_ready_count),
        .o_quantum_left   (o_quantum_left),
        .o_current_exited (o_current_exited),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // A generous ceiling: the slowest legal run stays well under a millisecond.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Counts a mismatch and tells whether it is still among the reported ones.
    function automatic bit log_mismatch();
        mismatch_count++;
        return mismatch_count <= 10;
    endfunction

    // Appends a task id to the ready ring; false when the ring is full.
    function automatic bit enqueue_task(input logic [TASK_W-1:0] id);
        if (ring_fill >= MAX_TASKS) begin
            return 1'b0;
        end
        ready_ring[ring_tail] = id;
        ring_tail = (ring_tail + 1) % MAX_TASKS;
        ring_fill++;
        return 1'b1;
    endfunction

    // Takes the head of the ring as the running task. The outgoing task goes
    // back to the tail unless it has exited. An empty ring changes nothing.
    function automatic bit rotate_task();
        logic [TASK_W-1:0] outgoing;
        if (ring_fill == 0) begin
            return 1'b0;
        end
        outgoing = running_id;
        running_id = ready_ring[ring_head];
        ring_head = (ring_head + 1) % MAX_TASKS;
        ring_fill--;
        if (!task_exited) begin
            void'(enqueue_task(outgoing));
        end
        task_exited = 1'b0;
        quantum_count = quantum_len;
        return 1'b1;
    endfunction

    // Advances the predicted state by one request and returns its response.
    function automatic t_result sched_step(input logic [CMD_W-1:0] cmd,
                                           input logic [TASK_W-1:0] id);
        t_result outcome;
        outcome = '0;
        case (cmd)
            CMD_ADD: begin
                outcome.add_rejected = !enqueue_task(id);
            end
            CMD_TICK: begin
                // The counter saturates at zero, and each tick at zero retries the switch.
                if (quantum_count != 0) begin
                    quantum_count--;
                end
                if (quantum_count == 0) begin
                    outcome.switched = rotate_task();
                end
            end
            CMD_EXIT: begin
                task_exited = 1'b1;
                outcome.switched = rotate_task();
            end
            default: begin
                outcome.switched = rotate_task();
            end
        endcase
        outcome.current_task   = running_id;
        outcome.ready_count    = RCNT_W'(ring_fill);
        outcome.quantum_left   = quantum_count;
        outcome.current_exited = task_exited;
        return outcome;
    endfunction

    function automatic void check_fields(input string origin, input t_result want,
                                         input t_result got);
        if (want.current_task !== got.current_task || want.switched !== got.switched ||
            want.add_rejected !== got.add_rejected || want.ready_count !== got.ready_count ||
            want.quantum_left !== got.quantum_left ||
            want.current_exited !== got.current_exited) begin
            if (log_mismatch()) begin
                $display("%0t: %s mismatch: task %0d/%0d switched %0d/%0d rejected %0d/%0d",
                         $realtime, origin, want.current_task, got.current_task,
                         want.switched, got.switched, want.add_rejected, got.add_rejected);
                $display("    ready %0d/%0d quantum %0d/%0d exited %0d/%0d (expected/actual)",
                         want.ready_count, got.ready_count, want.quantum_left,
                         got.quantum_left, want.current_exited, got.current_exited);
            end
        end
    endfunction

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Everything is sampled at the rising edge, where all testbench inputs have
    // been stable since the falling edge. Responses are checked before the
    // request of the same edge is predicted, since a response never belongs to
    // a request accepted at that very edge.
    always @(posedge i_clk) begin
        t_result  seen;
        t_awaited oldest;
        t_awaited fresh;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen.current_task   = o_current_task;
                seen.switched       = o_switched;
                seen.add_rejected   = o_add_rejected;
                seen.ready_count    = o_ready_count;
                seen.quantum_left   = o_quantum_left;
                seen.current_exited = o_current_exited;
                if (awaited_responses.size() == 0) begin
                    if (log_mismatch()) begin
                        $display("%0t: response with no request outstanding", $realtime);
                    end
                end else begin
                    oldest = awaited_responses.pop_front();
                    check_fields("predicted", oldest.predicted, seen);
                    if (oldest.typed) begin
                        check_fields("table", oldest.written, seen);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                fresh.predicted = sched_step(i_cmd, i_task_id);
                fresh.typed     = row_typed;
                fresh.written   = row_result;
                awaited_responses.push_back(fresh);
            end
            // The new quantum length takes effect at the next switch only.
            if (psel && penable && pwrite && pready && paddr == QUANTUM_ADDR) begin
                quantum_len = pwdata[QNT_W-1:0];
            end
        end
    end

    // Response side: random back-pressure, except during the steady phase.
    initial begin
        int stall_left;
        int pause;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (steady) begin
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                pause = pick_pause();
                if (pause == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    stall_left = pause - 1;
                end
            end
        end
    end

    // Offers one request and returns at the falling edge after it is taken.
    // Valid is only lowered when a gap is inserted, so back-to-back requests
    // keep it high without a glitch.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TASK_W-1:0] id,
                                input logic typed, input t_result result);
        int gap;
        gap = steady ? 0 : pick_pause();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_task_id  <= id;
        row_typed  <= typed;
        row_result <= result;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every outstanding response has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (awaited_responses.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [QNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= QUANTUM_ADDR;
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reads the quantum register back and compares it with the predicted value.
    task automatic apb_check_read();
        logic [APB_DW-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= QUANTUM_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data !== APB_DW'(quantum_len)) begin
            if (log_mismatch()) begin
                $display("%0t: quantum register read %0d, expected %0d",
                         $realtime, data, quantum_len);
            end
        end
    endtask

    initial begin
        int          add_weight;
        int          roll;
        logic [CMD_W-1:0] cmd;
        logic [QNT_W-1:0] setting;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The register must read its reset value before anything is written.
        apb_check_read();

        foreach (DIRECTED[row]) begin
            send_request(DIRECTED[row].cmd, DIRECTED[row].id, DIRECTED[row].typed,
                         DIRECTED[row].result);
        end
        drain();

        // Random phases, each under its own quantum length. Every phase change
        // happens with the block idle, which also exercises the sender pausing
        // until all responses are in.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            setting = (phase == DRAWN_PHASE) ? QNT_W'($urandom_range(4, 12))
                                             : QNT_W'(QUANTUM_PLAN[phase]);
            apb_write(setting);
            // The bus idles between the write and the read-back.
            @(negedge i_clk);
            apb_check_read();
            steady = (phase == STEADY_PHASE);
            add_weight = $urandom_range(25, 50);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Adds keep the ring busy; exits drain it, while ticks and yields rotate it.
                roll = $urandom_range(0, 99);
                if (roll < add_weight) begin
                    cmd = CMD_ADD;
                end else if (roll < add_weight + (100 - add_weight) * 55 / 100) begin
                    cmd = CMD_TICK;
                end else if (roll < add_weight + (100 - add_weight) * 70 / 100) begin
                    cmd = CMD_EXIT;
                end else begin
                    cmd = CMD_YIELD;
                end
                send_request(cmd, TASK_W'($urandom_range(0, 15)), 1'b0, '0);
                if (!steady && $urandom_range(0, 149) == 0) begin
                    drain();
                end
            end
            drain();
        end

        steady = 1'b0;
        // Give a stray late response a chance to show up.
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_responses.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
